/* design/bmbc_pkg.sv */
// Shared types and constants for the bad-character search block.
// No dependencies; imported by every module of the block.
package bmbc_pkg;

    localparam int PATTERN_MAX_DEF = 128;
    localparam int LINE_MAX_DEF    = 256;

    localparam int BYTE_W      = 8;
    localparam int TBL_DEPTH   = 256;
    localparam int LCNT_W      = 9;
    localparam int TOT_W       = 32;
    localparam int OUT_FIELD_W = 2 * LCNT_W + 2 * TOT_W + 1;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [LCNT_W-1:0] LCNT_MAX = '1;
    localparam logic [TOT_W-1:0]  TOT_MAX  = '1;

    // tuser codes on the input side
    localparam logic FUNC_PATTERN = 1'b0;
    localparam logic FUNC_TEXT    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,   // taking bytes
        ST_CHK,    // window still fits?
        ST_RD,     // read pattern[j] and line[s+j]
        ST_CMP,    // compare, count
        ST_NXT,    // line byte after window ready, look it up
        ST_MSH,    // shift after mismatch
        ST_HSH,    // shift after full match
        ST_DONE    // hand result to output register
    } state_t;

    typedef struct packed {
        logic take;        // input transfer this cycle
        logic start;       // zero window position and line counts
        logic init_j;      // j = m - 1
        logic rd_win;      // read pattern[j], line[s+j]
        logic dec_j;
        logic hit;
        logic miss;
        logic rd_next;     // read line[s+m]
        logic rd_tbl;      // look up table at last line byte read
        logic step_one;
        logic shift_miss;
        logic shift_hit;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic eq;
        logic j_zero;
        logic next_in;     // s + m < n
        logic fits;        // s + m <= n
        logic m_zero;
        logic out_free;
    } sts_t;

endpackage

/* design/bmbc_ctrl.sv */
// Sequencer for the search: input handshake, window loop, result hand-off.
// Depends on bmbc_pkg; drives bmbc_dp through cmd_t, reads sts_t.
module bmbc_ctrl
    import bmbc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_func,
    input  logic in_last,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
                if (in_valid && in_func == FUNC_TEXT && in_last)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                if (!sts.m_zero && sts.fits)
                begin
                    cmd.init_j = 1'b1;
                    state_next = ST_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RD:
            begin
                cmd.rd_win = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (!sts.eq)
                begin
                    cmd.miss   = 1'b1;
                    cmd.rd_tbl = 1'b1;
                    state_next = ST_MSH;
                end
                else if (!sts.j_zero)
                begin
                    cmd.dec_j  = 1'b1;
                    state_next = ST_RD;
                end
                else if (sts.next_in)
                begin
                    cmd.hit     = 1'b1;
                    cmd.rd_next = 1'b1;
                    state_next  = ST_NXT;
                end
                else
                begin
                    cmd.hit      = 1'b1;
                    cmd.step_one = 1'b1;
                    state_next   = ST_CHK;
                end
            end
            ST_NXT:
            begin
                cmd.rd_tbl = 1'b1;
                state_next = ST_HSH;
            end
            ST_MSH:
            begin
                cmd.shift_miss = 1'b1;
                state_next     = ST_CHK;
            end
            ST_HSH:
            begin
                cmd.shift_hit = 1'b1;
                state_next    = ST_CHK;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* design/bmbc_dp.sv */
// Datapath: pattern, line and last-occurrence memories, window registers,
// counters and the output register. Depends on bmbc_pkg; driven by bmbc_ctrl.
module bmbc_dp
    import bmbc_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int LINE_MAX    = LINE_MAX_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    input  logic                   in_func,
    input  logic [BYTE_W-1:0]      in_byte,
    input  logic                   in_last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [LCNT_W-1:0]      out_line_matches,
    output logic [LCNT_W-1:0]      out_line_switches,
    output logic [TOT_W-1:0]       out_total_matches,
    output logic [TOT_W-1:0]       out_total_switches,
    output logic                   out_line_overflow
);

    localparam int PW   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int PLW  = $clog2(PATTERN_MAX + 1);
    localparam int LAW  = $clog2(LINE_MAX);
    localparam int LW   = $clog2(LINE_MAX + 1);
    localparam int SW   = LW + 1;
    localparam int SHW  = PLW + 1;
    localparam int CW   = ((SW > SHW) ? SW : SHW) + 1;

    // memories
    logic [BYTE_W-1:0] pat_mem [PATTERN_MAX];
    logic [BYTE_W-1:0] line_mem [LINE_MAX];
    logic [PW-1:0]     tbl_mem [TBL_DEPTH];

    logic [BYTE_W-1:0] pat_q;
    logic [BYTE_W-1:0] line_q;
    logic [PW-1:0]     tbl_q;
    logic              tbl_v_q;

    // control state
    logic [TBL_DEPTH-1:0] tbl_vld_reg, tbl_vld_next;
    logic [PLW-1:0]       plen_reg, plen_next;
    logic                 loading_reg, loading_next;
    logic [LW-1:0]        llen_reg, llen_next;
    logic                 ovf_reg, ovf_next;
    logic [TOT_W-1:0]     tot_m_reg, tot_m_next;
    logic [TOT_W-1:0]     tot_w_reg, tot_w_next;
    logic                 out_valid_reg, out_valid_next;

    // window state
    logic [SW-1:0]     s_reg, s_next;
    logic [PW-1:0]     j_reg, j_next;
    logic [LCNT_W-1:0] hits_reg, hits_next;
    logic [LCNT_W-1:0] sw_reg, sw_next;

    logic [PLW-1:0]    p_idx;
    logic              p_wr;
    logic              l_wr;
    logic [CW-1:0]     s_plus_m;
    logic [CW-1:0]     s_plus_j;
    logic [SHW-1:0]    miss_shift;
    logic [SHW-1:0]    hit_shift;
    logic [CW-1:0]     s_sum;

    // pattern writes start at 0 on the first byte of a new load
    assign p_idx = loading_reg ? plen_reg : '0;
    assign p_wr  = cmd.take && in_func == FUNC_PATTERN && p_idx < PLW'(PATTERN_MAX);
    assign l_wr  = cmd.take && in_func == FUNC_TEXT && llen_reg < LW'(LINE_MAX);

    assign s_plus_m = CW'(s_reg) + CW'(plen_reg);
    assign s_plus_j = CW'(s_reg) + CW'(j_reg);

    always_comb
    begin
        if (!tbl_v_q)
        begin
            miss_shift = SHW'(j_reg) + SHW'(1);
            hit_shift  = SHW'(plen_reg) + SHW'(1);
        end
        else
        begin
            miss_shift = (SHW'(tbl_q) >= SHW'(j_reg)) ? SHW'(1)
                                                      : SHW'(j_reg) - SHW'(tbl_q);
            hit_shift  = SHW'(plen_reg) - SHW'(tbl_q);
        end
        if (cmd.shift_miss)
        begin
            s_sum = CW'(s_reg) + CW'(miss_shift);
        end
        else if (cmd.shift_hit)
        begin
            s_sum = CW'(s_reg) + CW'(hit_shift);
        end
        else
        begin
            s_sum = CW'(s_reg) + CW'(1);
        end
    end

    always_comb
    begin
        tbl_vld_next   = tbl_vld_reg;
        plen_next      = plen_reg;
        loading_next   = loading_reg;
        llen_next      = llen_reg;
        ovf_next       = ovf_reg;
        tot_m_next     = tot_m_reg;
        tot_w_next     = tot_w_reg;
        out_valid_next = out_valid_reg;
        s_next         = s_reg;
        j_next         = j_reg;
        hits_next      = hits_reg;
        sw_next        = sw_reg;

        if (cmd.take && in_func == FUNC_PATTERN)
        begin
            if (!loading_reg)
            begin
                tbl_vld_next = '0;
                tot_m_next   = '0;
                tot_w_next   = '0;
            end
            if (p_wr)
            begin
                tbl_vld_next[in_byte] = 1'b1;
                plen_next             = p_idx + PLW'(1);
            end
            else
            begin
                plen_next = p_idx;
            end
            loading_next = !in_last;
        end
        if (cmd.take && in_func == FUNC_TEXT)
        begin
            loading_next = 1'b0;
            if (l_wr)
            begin
                llen_next = llen_reg + LW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end

        if (cmd.start)
        begin
            s_next    = '0;
            hits_next = '0;
            sw_next   = '0;
        end
        if (cmd.init_j)
        begin
            j_next = PW'(plen_reg - PLW'(1));
        end
        if (cmd.dec_j)
        begin
            j_next = j_reg - PW'(1);
        end
        if (cmd.hit)
        begin
            hits_next  = (hits_reg == LCNT_MAX) ? hits_reg : hits_reg + LCNT_W'(1);
            tot_m_next = (tot_m_reg == TOT_MAX) ? tot_m_reg : tot_m_reg + TOT_W'(1);
        end
        if (cmd.miss)
        begin
            sw_next    = (sw_reg == LCNT_MAX) ? sw_reg : sw_reg + LCNT_W'(1);
            tot_w_next = (tot_w_reg == TOT_MAX) ? tot_w_reg : tot_w_reg + TOT_W'(1);
        end
        if (cmd.step_one || cmd.shift_miss || cmd.shift_hit)
        begin
            s_next = SW'(s_sum);
        end

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            llen_next      = '0;
            ovf_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_vld_reg   <= '0;
            plen_reg      <= '0;
            loading_reg   <= 1'b0;
            llen_reg      <= '0;
            ovf_reg       <= 1'b0;
            tot_m_reg     <= '0;
            tot_w_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tbl_vld_reg   <= tbl_vld_next;
            plen_reg      <= plen_next;
            loading_reg   <= loading_next;
            llen_reg      <= llen_next;
            ovf_reg       <= ovf_next;
            tot_m_reg     <= tot_m_next;
            tot_w_reg     <= tot_w_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg    <= s_next;
        j_reg    <= j_next;
        hits_reg <= hits_next;
        sw_reg   <= sw_next;
        if (cmd.emit)
        begin
            out_line_matches   <= hits_reg;
            out_line_switches  <= sw_reg;
            out_total_matches  <= tot_m_reg;
            out_total_switches <= tot_w_reg;
            out_line_overflow  <= ovf_reg;
        end
    end

    // pattern store
    always_ff @(posedge clk)
    begin
        if (p_wr)
        begin
            pat_mem[p_idx[PW-1:0]] <= in_byte;
        end
        if (cmd.rd_win)
        begin
            pat_q <= pat_mem[j_reg];
        end
    end

    // line store
    always_ff @(posedge clk)
    begin
        if (l_wr)
        begin
            line_mem[llen_reg[LAW-1:0]] <= in_byte;
        end
        if (cmd.rd_win)
        begin
            line_q <= line_mem[s_plus_j[LAW-1:0]];
        end
        else if (cmd.rd_next)
        begin
            line_q <= line_mem[s_plus_m[LAW-1:0]];
        end
    end

    // last-occurrence table, absent entries tracked by tbl_vld_reg
    always_ff @(posedge clk)
    begin
        if (p_wr)
        begin
            tbl_mem[in_byte] <= p_idx[PW-1:0];
        end
        if (cmd.rd_tbl)
        begin
            tbl_q   <= tbl_mem[line_q];
            tbl_v_q <= tbl_vld_reg[line_q];
        end
    end

    assign sts.eq       = pat_q == line_q;
    assign sts.j_zero   = j_reg == '0;
    assign sts.next_in  = s_plus_m < CW'(llen_reg);
    assign sts.fits     = s_plus_m <= CW'(llen_reg);
    assign sts.m_zero   = plen_reg == '0;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;

endmodule

/* design/boyer_moore_bad_char_search.sv */
// Top level of the bad-character string search block.
// Depends on bmbc_pkg, bmbc_ctrl and bmbc_dp.
//
// Usage:
//   Slave side (s_*) takes one byte per transfer. s_tuser = 0 marks a
//   pattern byte, 1 a text byte; s_tlast marks the final byte of a pattern
//   or of a line. The first pattern byte after anything else starts a new
//   pattern and clears the table and both running totals.
//   Master side (m_*) gives one result per text line, on its last byte.
//
// Timing:
//   Pattern bytes and non-final text bytes: one per cycle, no result.
//   Final text byte: s_tready drops while the stored line is searched.
//   Each window runs a fit check, then a memory read and a compare per
//   byte compared; a mismatch adds a shift step (the table lookup overlaps
//   the compare), a full match that is not at the line end adds a table
//   lookup step and a shift step. The loop through the registered memory
//   reads sets the pace. When the search ends, the result is loaded into
//   the output register as soon as that register is free.
//   If m_tready is low the result waits there; the block stops after the
//   next line's search until the slot frees, and takes no input meanwhile.
//   Reset: table all absent, lengths and totals zero, no result pending.
module boyer_moore_bad_char_search
    import bmbc_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int LINE_MAX    = LINE_MAX_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] data_byte
    input  logic                   s_tuser,   // [0] func
    input  logic                   s_tlast,   // last_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [8:0] line_matches, [17:9] line_switches, [49:18] total_matches,
    // [81:50] total_switches, [82] line_overflow, [87:83] zero
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    cmd_t cmd;
    sts_t sts;

    logic [LCNT_W-1:0] line_matches;
    logic [LCNT_W-1:0] line_switches;
    logic [TOT_W-1:0]  total_matches;
    logic [TOT_W-1:0]  total_switches;
    logic              line_overflow;

    bmbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_func  (s_tuser),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bmbc_dp #(
        .PATTERN_MAX (PATTERN_MAX),
        .LINE_MAX    (LINE_MAX)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .in_func            (s_tuser),
        .in_byte            (s_tdata),
        .in_last            (s_tlast),
        .out_valid          (m_tvalid),
        .out_ready          (m_tready),
        .out_line_matches   (line_matches),
        .out_line_switches  (line_switches),
        .out_total_matches  (total_matches),
        .out_total_switches (total_switches),
        .out_line_overflow  (line_overflow)
    );

    assign m_tdata = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, line_overflow,
                      total_switches, total_matches, line_switches, line_matches};

endmodule

/* design/bmbc_checker.sv */
// Port-level checks for boyer_moore_bad_char_search, bound to the top level.
// Depends on bmbc_pkg.
module bmbc_checker
    import bmbc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [BYTE_W-1:0]      s_tdata,
    input logic                   s_tuser,
    input logic                   s_tlast,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // end of line starts a search, input closes
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == FUNC_TEXT && s_tlast |=> !s_tready)
        else $error("input open right after end of line");

    // pattern bytes stream without pause
    a_pattern_stream: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == FUNC_PATTERN |=> s_tready)
        else $error("input closed after pattern byte");

    // a new result only comes out of a search
    a_result_after_search: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without search");

    // running total covers this line
    a_total_covers_line: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[49:18] >= TOT_W'(m_tdata[8:0]))
        else $error("total matches below line matches");

endmodule

bind boyer_moore_bad_char_search bmbc_checker u_bmbc_checker (.*);

/* bench/tb_boyer_moore_bad_char_search.sv */
// Self-checking bench for boyer_moore_bad_char_search: a scoreboard class that tracks
// pattern, table and totals, and a top module that drives byte streams.
// Depends on bmbc_pkg and the design sources; needs nothing else.

import bmbc_pkg::*;

// Result word as it sits on m_tdata, lowest field last in the declaration.
typedef struct packed {
    logic [OUT_TDATA_W-OUT_FIELD_W-1:0] pad;
    logic                               overflow;
    logic [TOT_W-1:0]                   tot_switches;
    logic [TOT_W-1:0]                   tot_matches;
    logic [LCNT_W-1:0]                  line_switches;
    logic [LCNT_W-1:0]                  line_matches;
} line_result_t;

class search_scoreboard;
    bit [BYTE_W-1:0]  pat_bytes[PATTERN_MAX_DEF];
    int               pat_len;
    int               last_pos[TBL_DEPTH];
    bit [BYTE_W-1:0]  line_bytes[LINE_MAX_DEF];
    int               line_len;
    bit [TOT_W-1:0]   hit_total;
    bit [TOT_W-1:0]   shift_total;
    bit               loading;
    bit               dropped;
    line_result_t     expected_lines[$];
    int               errors;
    int               lines_checked;
    int               overflow_lines;
    int               hits_seen;
    int               loads;

    function new();
        pat_len = 0;
        line_len = 0;
        hit_total = '0;
        shift_total = '0;
        loading = 0;
        dropped = 0;
        errors = 0;
        lines_checked = 0;
        overflow_lines = 0;
        hits_seen = 0;
        loads = 0;
        foreach (last_pos[k])
            last_pos[k] = -1;
    endfunction

    function bit [TOT_W-1:0] sat_add(bit [TOT_W-1:0] a, int unsigned b);
        bit [TOT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TOT_W] ? TOT_MAX : sum[TOT_W-1:0];
    endfunction

    // Bad-character scan of the stored line; counts full matches and
    // mismatch shifts.
    function void bad_char_scan(output int hits, output int shifts);
        int s;
        int j;
        int d;
        hits = 0;
        shifts = 0;
        s = 0;
        if (pat_len == 0)
            return;
        while (s <= line_len - pat_len) begin
            j = pat_len - 1;
            while (j >= 0 && pat_bytes[j] == line_bytes[s + j])
                j--;
            if (j < 0) begin
                hits++;
                if (s + pat_len < line_len)
                    s += pat_len - last_pos[line_bytes[s + pat_len]];
                else
                    s += 1;
            end
            else begin
                d = j - last_pos[line_bytes[s + j]];
                shifts++;
                s += (d > 1) ? d : 1;
            end
        end
    endfunction

    // Called for every accepted input transfer.
    function void note_byte(logic func, bit [BYTE_W-1:0] b, bit last);
        int           hits;
        int           shifts;
        line_result_t r;
        if (func == FUNC_PATTERN) begin
            if (!loading) begin
                pat_len = 0;
                hit_total = '0;
                shift_total = '0;
                foreach (last_pos[k])
                    last_pos[k] = -1;
                loading = 1;
                loads++;
            end
            if (pat_len < PATTERN_MAX_DEF) begin
                pat_bytes[pat_len] = b;
                last_pos[b] = pat_len;
                pat_len++;
            end
            if (last)
                loading = 0;
            return;
        end
        loading = 0;
        if (line_len < LINE_MAX_DEF) begin
            line_bytes[line_len] = b;
            line_len++;
        end
        else
            dropped = 1;
        if (!last)
            return;
        bad_char_scan(hits, shifts);
        hit_total = sat_add(hit_total, hits);
        shift_total = sat_add(shift_total, shifts);
        r = '0;
        r.line_matches = (hits > LCNT_MAX) ? LCNT_MAX : hits[LCNT_W-1:0];
        r.line_switches = (shifts > LCNT_MAX) ? LCNT_MAX : shifts[LCNT_W-1:0];
        r.tot_matches = hit_total;
        r.tot_switches = shift_total;
        r.overflow = dropped;
        expected_lines.push_back(r);
        line_len = 0;
        dropped = 0;
    endfunction

    task report(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task field_check(string name, logic [TOT_W-1:0] got, logic [TOT_W-1:0] want);
        if (got !== want)
            report($sformatf("line %0d %s = %0d, expected %0d", lines_checked, name, got, want));
    endtask

    // Called for every accepted output transfer.
    task check_result(logic [OUT_TDATA_W-1:0] word);
        line_result_t got;
        line_result_t want;
        got = word;
        if (expected_lines.size() == 0) begin
            report("result transfer with no line pending");
            return;
        end
        want = expected_lines.pop_front();
        lines_checked++;
        field_check("line_matches", TOT_W'(got.line_matches), TOT_W'(want.line_matches));
        field_check("line_switches", TOT_W'(got.line_switches), TOT_W'(want.line_switches));
        field_check("total_matches", got.tot_matches, want.tot_matches);
        field_check("total_switches", got.tot_switches, want.tot_switches);
        field_check("line_overflow", TOT_W'(got.overflow), TOT_W'(want.overflow));
        field_check("padding", TOT_W'(got.pad), TOT_W'(want.pad));
        if (want.overflow)
            overflow_lines++;
        hits_seen += want.line_matches;
    endtask
endclass

module tb_boyer_moore_bad_char_search;
    import bmbc_pkg::*;

    typedef bit [BYTE_W-1:0] byte_q_t[$];

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata;    // [7:0] data_byte
    logic                   s_tuser;    // [0] func
    logic                   s_tlast;    // last_byte
    logic                   m_tvalid;
    logic                   m_tready;
    // [8:0] line_matches, [17:9] line_switches, [49:18] total_matches,
    // [81:50] total_switches, [82] line_overflow, [87:83] zero
    logic [OUT_TDATA_W-1:0] m_tdata;

    search_scoreboard sb;
    bit               gaps_on;
    int               items_sent;
    int               stall_left;

    boyer_moore_bad_char_search uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
        clk = 1'b0;
    always #1 clk = ~clk;

    // Hard stop: far beyond the slowest legal run.
    initial
    begin
        #4000000;
        $display("** boyer_moore_bad_char_search: FAILED **");
        $finish;
    end

    // Result side back-pressure: random bursts of low m_tready while gaps_on.
    always @(posedge clk)
    begin
        if (!gaps_on)
            m_tready <= 1'b1;
        else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Output transfer monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // One input transfer; an optional gap with s_tvalid low goes first.
    task send_byte(logic func, bit [BYTE_W-1:0] b, bit last);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_byte(func, b, last);
        items_sent++;
    endtask

    // A run of bytes; tlast on the final one only when close is set.
    task send_run(logic func, byte_q_t q, bit close);
        foreach (q[i])
            send_byte(func, q[i], close && (i == q.size() - 1));
    endtask

    function automatic byte_q_t from_text(string t);
        byte_q_t q;
        for (int i = 0; i < t.len(); i++)
            q.push_back(t[i]);
        return q;
    endfunction

    // span 256 gives the full byte range, smaller spans a tiny alphabet
    function automatic byte_q_t rand_bytes(int n, int span);
        byte_q_t q;
        for (int i = 0; i < n; i++)
            q.push_back(span >= 256 ? 8'($urandom_range(0, 255))
                                    : 8'(8'h61 + $urandom_range(0, span - 1)));
        return q;
    endfunction

    // Line of roughly len bytes, seeded with copies of the pattern.
    function automatic byte_q_t rand_line(int len, int span, byte_q_t pat);
        byte_q_t q;
        while (q.size() < len) begin
            if ($urandom_range(0, 3) == 0 && pat.size() <= len - q.size())
                q = {q, pat};
            else
                q = {q, rand_bytes(1, span)};
        end
        return q;
    endfunction

    initial
    begin
        byte_q_t pat;
        byte_q_t q;
        int      span;
        int      plen;
        int      llen;
        sb = new();
        gaps_on = 0;
        items_sent = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= FUNC_PATTERN;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: line with no pattern loaded yet (empty pattern)
        send_run(FUNC_TEXT, from_text("abab"), 1);
        // extreme byte values
        send_run(FUNC_PATTERN, '{8'h00, 8'hFF}, 1);
        send_run(FUNC_TEXT, '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF}, 1);
        // pattern longer than line, match at line end, match followed by a byte
        send_run(FUNC_PATTERN, from_text("abc"), 1);
        send_run(FUNC_TEXT, from_text("ab"), 1);
        send_run(FUNC_TEXT, from_text("abc"), 1);
        send_run(FUNC_TEXT, from_text("abcabcxabc"), 1);
        // back-to-back loads: the second clears the first and the totals
        send_run(FUNC_PATTERN, from_text("pq"), 1);
        send_run(FUNC_PATTERN, from_text("q"), 1);
        send_run(FUNC_TEXT, from_text("qaq"), 1);
        // pattern cut short by text: the load ends there
        send_run(FUNC_PATTERN, from_text("xy"), 0);
        send_run(FUNC_TEXT, from_text("xyzxy"), 1);
        // pattern beyond capacity, then the repetitive worst case
        pat = {rand_bytes(PATTERN_MAX_DEF, 1), from_text("zz")};
        send_run(FUNC_PATTERN, pat, 1);
        send_run(FUNC_TEXT, rand_bytes(LINE_MAX_DEF, 1), 1);
        // line overflow, a dropped final byte, then the flag clears
        send_run(FUNC_PATTERN, from_text("ab"), 1);
        send_run(FUNC_TEXT, rand_bytes(LINE_MAX_DEF + 44, 2), 1);
        send_run(FUNC_TEXT, rand_bytes(LINE_MAX_DEF + 1, 2), 1);
        send_run(FUNC_TEXT, from_text("abab"), 1);

        // Random: mostly pattern loads followed by lines, some noise
        while (items_sent < 1750) begin
            gaps_on = (items_sent < 1500) && ($urandom_range(0, 3) != 0);
            span = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(2, 4);
            case ($urandom_range(0, 19))
                0: begin
                    send_run(FUNC_PATTERN, rand_bytes($urandom_range(1, 4), 256), 0);
                    send_run(FUNC_TEXT, rand_bytes($urandom_range(1, 30), 256), 1);
                end
                1: send_run(FUNC_TEXT, rand_bytes($urandom_range(1, 30), span), 1);
                2: send_run(FUNC_PATTERN, rand_bytes($urandom_range(1, 6), 256), 1);
                default: begin
                    plen = ($urandom_range(0, 29) == 0) ? $urandom_range(100, 140)
                                                        : $urandom_range(1, 6);
                    pat = rand_bytes(plen, span);
                    send_run(FUNC_PATTERN, pat, 1);
                    repeat ($urandom_range(1, 5)) begin
                        llen = ($urandom_range(0, 29) == 0) ? $urandom_range(240, 280)
                                                            : $urandom_range(1, 40);
                        q = rand_line(llen, span, pat);
                        send_run(FUNC_TEXT, q, 1);
                    end
                end
            endcase
        end
        gaps_on = 0;
        s_tvalid <= 1'b0;

        while (sb.expected_lines.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        $display("Run covered %0d input transfers, %0d pattern loads, %0d lines checked",
                 items_sent, sb.loads, sb.lines_checked);
        $display("(%0d truncated lines, %0d matches, %0d mismatches found)",
                 sb.overflow_lines, sb.hits_seen, sb.errors);
        if (sb.errors == 0)
            $display("** boyer_moore_bad_char_search: PASSED **");
        else
            $display("** boyer_moore_bad_char_search: FAILED **");
        $finish;
    end

endmodule

/* files.f */
design/bmbc_pkg.sv
design/bmbc_ctrl.sv
design/bmbc_dp.sv
design/boyer_moore_bad_char_search.sv
design/bmbc_checker.sv
bench/tb_boyer_moore_bad_char_search.sv
